[rtl/cclat_pkg.sv]
// shared types and constants for the cyclic competition lattice step core
package cclat_pkg;

    localparam int unsigned CfgW   = 17;
    localparam int unsigned CoordW = 9;
    localparam int unsigned CountW = 19;
    localparam int unsigned DrawW  = 16;

    localparam logic [CfgW-1:0] MobilityReset    = 17'd39322;
    localparam logic [CfgW-1:0] ReproWidthReset  = 17'd16384;
    localparam logic [CfgW-1:0] PredationReset   = 17'd65536;

    typedef enum logic [1:0] {
        CFG_MOBILITY  = 2'd0,
        CFG_REPRO     = 2'd1,
        CFG_PREDATION = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_SWAP      = 3'd1,
        ACT_REPRODUCE = 3'd2,
        ACT_PREDATION = 3'd3,
        ACT_NO_CHANGE = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_UP    = 2'd3
    } t_dir;

    localparam logic FUNC_WRITE    = 1'b0;
    localparam logic FUNC_INTERACT = 1'b1;

    typedef struct packed {
        logic              func;
        logic [CoordW-1:0] col;
        logic [CoordW-1:0] row;
        logic [1:0]        species;
        logic [1:0]        direction;
        logic [DrawW-1:0]  draw_action;
        logic [DrawW-1:0]  draw_predation;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        action;
        logic [CountW-1:0] count_empty;
        logic [CountW-1:0] count_first;
        logic [CountW-1:0] count_second;
        logic [CountW-1:0] count_third;
    } t_out_item;

    function automatic logic beats(input logic [1:0] a, input logic [1:0] b);
        return (a == 2'd1 && b == 2'd2) || (a == 2'd2 && b == 2'd3) ||
               (a == 2'd3 && b == 2'd1);
    endfunction

endpackage

[rtl/cclat_front.sv]
// front end: wraps coordinates, computes both cell addresses, queues commands
module cclat_front
    import cclat_pkg::*;
#(
    parameter int unsigned COLS = 512,
    parameter int unsigned ROWS = 512,
    parameter int unsigned CW   = $clog2(COLS),
    parameter int unsigned RW   = $clog2(ROWS),
    parameter int unsigned AW   = CW + RW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  t_in_item           i_item,
    output logic               o_cmd_valid,
    input  logic               i_cmd_take,
    output logic               o_cmd_func,
    output logic [AW-1:0]      o_cmd_act,
    output logic [AW-1:0]      o_cmd_pas,
    output logic [1:0]         o_cmd_species,
    output logic [DrawW-1:0]   o_cmd_draw_a,
    output logic [DrawW-1:0]   o_cmd_draw_p
);

    localparam int unsigned QW = 1 + 2*AW + 2 + 2*DrawW;

    logic [CW-1:0] w_col, w_ncol;
    logic [RW-1:0] w_row, w_nrow;
    logic [QW-1:0] w_entry;
    logic [QW-1:0] r_q [2];
    logic [QW-1:0] w_head;
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_push_ok, w_pop_ok;

    // coordinate wrap: inputs are below 2*size for sizes above 256
    function automatic logic [CW-1:0] wrap_col(input logic [CoordW-1:0] c);
        logic [31:0] v;
        v = 32'(c);
        while (v >= COLS) v = v - COLS;
        return CW'(v);
    endfunction

    function automatic logic [RW-1:0] wrap_row(input logic [CoordW-1:0] r);
        logic [31:0] v;
        v = 32'(r);
        while (v >= ROWS) v = v - ROWS;
        return RW'(v);
    endfunction

    always_comb begin
        w_col  = wrap_col(i_item.col);
        w_row  = wrap_row(i_item.row);
        w_ncol = w_col;
        w_nrow = w_row;
        unique case (t_dir'(i_item.direction))
            DIR_RIGHT: w_ncol = (32'(w_col) == COLS - 1) ? '0 : w_col + CW'(1);
            DIR_LEFT:  w_ncol = (w_col == '0) ? CW'(COLS - 1) : w_col - CW'(1);
            DIR_DOWN:  w_nrow = (32'(w_row) == ROWS - 1) ? '0 : w_row + RW'(1);
            DIR_UP:    w_nrow = (w_row == '0) ? RW'(ROWS - 1) : w_row - RW'(1);
            default:   w_ncol = w_col;
        endcase
    end

    assign w_entry = {i_item.func, w_row, w_col, w_nrow, w_ncol, i_item.species,
                      i_item.draw_action, i_item.draw_predation};

    assign o_full     = (r_cnt == 2'd2);
    assign w_push_ok  = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop_ok   = i_cmd_take && o_cmd_valid;
    assign w_head     = r_q[r_rp];

    assign {o_cmd_func, o_cmd_act, o_cmd_pas, o_cmd_species, o_cmd_draw_a,
            o_cmd_draw_p} = w_head;

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_q[r_wp] <= w_entry;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push_ok) r_wp <= ~r_wp;
            if (w_pop_ok)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push_ok) - 2'(w_pop_ok);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !w_push_ok) else $error("queue overflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop_ok |-> r_cnt != 2'd0) else $error("pop from empty queue");
`endif

endmodule

[rtl/cclat_back.sv]
// back end: clears lattice after reset, runs cell read-modify-write, output queue
module cclat_back
    import cclat_pkg::*;
#(
    parameter int unsigned COLS = 512,
    parameter int unsigned ROWS = 512,
    parameter int unsigned AW   = $clog2(COLS) + $clog2(ROWS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CfgW-1:0]    i_mob,
    input  logic [CfgW-1:0]    i_repw,
    input  logic [CfgW-1:0]    i_pred,
    input  logic               i_cmd_valid,
    output logic               o_cmd_take,
    input  logic               i_cmd_func,
    input  logic [AW-1:0]      i_cmd_act,
    input  logic [AW-1:0]      i_cmd_pas,
    input  logic [1:0]         i_cmd_species,
    input  logic [DrawW-1:0]   i_cmd_draw_a,
    input  logic [DrawW-1:0]   i_cmd_draw_p,
    output logic               o_empty,
    input  logic               i_pop,
    output t_out_item          o_item
);

    localparam int unsigned CELLS = COLS * ROWS;
    // address is {row, col}, so the memory spans the full power-of-two space
    localparam int unsigned DEPTH = 1 << AW;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_RDP   = 5'b00100,
        ST_EXEC  = 5'b01000,
        ST_WRP   = 5'b10000
    } t_state;

    logic [1:0]        r_mem [DEPTH];
    logic [1:0]        r_rd;
    logic              w_we;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [1:0]        w_wdata;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr;
    logic [1:0]        r_a, n_a;
    logic [2:0]        n_act;
    logic [CountW-1:0] r_cnt [4];
    logic [1:0]        w_dec, w_inc;
    logic              w_cnt_upd;
    logic              w_emit;
    logic [1:0]        r_pas_wr, n_pas_wr;

    t_out_item         r_oq [2];
    t_out_item         w_out;
    logic              r_owp, r_orp;
    logic [1:0]        r_ocnt;
    logic              w_pop_ok;
    logic [CfgW:0]     w_band;

    assign w_band   = {1'b0, i_mob} + {1'b0, i_repw};
    assign w_pop_ok = i_pop && !o_empty;
    assign o_empty  = (r_ocnt == 2'd0);
    assign o_item   = r_oq[r_orp];

    always_comb begin
        n_state    = r_state;
        o_cmd_take = 1'b0;
        w_we       = 1'b0;
        w_waddr    = i_cmd_act;
        w_wdata    = i_cmd_species;
        w_raddr    = i_cmd_act;
        w_cnt_upd  = 1'b0;
        w_dec      = r_rd;
        w_inc      = i_cmd_species;
        w_emit     = 1'b0;
        n_act      = ACT_NONE;
        n_a        = r_a;
        n_pas_wr   = r_pas_wr;
        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = 2'd0;
                if (&r_clr) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                // room in result queue guaranteed: at most one result in flight
                if (i_cmd_valid && r_ocnt != 2'd2) n_state = ST_RDP;
            end
            ST_RDP: begin
                // r_rd holds active cell; fetch neighbour
                n_a     = r_rd;
                w_raddr = i_cmd_pas;
                if (i_cmd_func == FUNC_WRITE) begin
                    w_we       = 1'b1;
                    w_cnt_upd  = 1'b1;
                    w_emit     = 1'b1;
                    o_cmd_take = 1'b1;
                    n_state    = ST_IDLE;
                end else if (r_rd == 2'd0) begin
                    w_emit     = 1'b1;
                    o_cmd_take = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // r_a active species, r_rd neighbour species
                w_emit     = 1'b1;
                o_cmd_take = 1'b1;
                n_state    = ST_IDLE;
                if ({1'b0, i_cmd_draw_a} < i_mob) begin
                    // command stays at the head until the second write
                    w_emit     = 1'b0;
                    o_cmd_take = 1'b0;
                    w_we       = 1'b1;
                    w_wdata    = r_rd;
                    n_pas_wr   = r_a;
                    n_act      = ACT_SWAP;
                    n_state    = ST_WRP;
                end else if ({2'b0, i_cmd_draw_a} < w_band) begin
                    if (r_rd == 2'd0) begin
                        w_we      = 1'b1;
                        w_waddr   = i_cmd_pas;
                        w_wdata   = r_a;
                        w_cnt_upd = 1'b1;
                        w_inc     = r_a;
                        n_act     = ACT_REPRODUCE;
                    end else begin
                        n_act = ACT_NO_CHANGE;
                    end
                end else if (r_rd != 2'd0 && beats(r_a, r_rd) &&
                             {1'b0, i_cmd_draw_p} < i_pred) begin
                    w_we      = 1'b1;
                    w_waddr   = i_cmd_pas;
                    w_wdata   = 2'd0;
                    w_cnt_upd = 1'b1;
                    w_inc     = 2'd0;
                    n_act     = ACT_PREDATION;
                end else begin
                    n_act = ACT_NO_CHANGE;
                end
            end
            ST_WRP: begin
                // swap second write, then retire the command and queue its result
                w_we       = 1'b1;
                w_waddr    = i_cmd_pas;
                w_wdata    = r_pas_wr;
                w_emit     = 1'b1;
                o_cmd_take = 1'b1;
                n_act      = ACT_SWAP;
                n_state    = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        w_out.action = n_act;
        w_out.count_empty  = r_cnt[0];
        w_out.count_first  = r_cnt[1];
        w_out.count_second = r_cnt[2];
        w_out.count_third  = r_cnt[3];
        if (w_cnt_upd) begin
            w_out.count_empty  = r_cnt[0] - CountW'(w_dec == 2'd0) + CountW'(w_inc == 2'd0);
            w_out.count_first  = r_cnt[1] - CountW'(w_dec == 2'd1) + CountW'(w_inc == 2'd1);
            w_out.count_second = r_cnt[2] - CountW'(w_dec == 2'd2) + CountW'(w_inc == 2'd2);
            w_out.count_third  = r_cnt[3] - CountW'(w_dec == 2'd3) + CountW'(w_inc == 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_pas_wr <= n_pas_wr;
        if (w_emit) r_oq[r_owp] <= w_out;
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_cnt[0] <= CountW'(CELLS);
            r_cnt[1] <= '0;
            r_cnt[2] <= '0;
            r_cnt[3] <= '0;
            r_owp   <= 1'b0;
            r_orp   <= 1'b0;
            r_ocnt  <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + AW'(1);
            if (w_cnt_upd) begin
                r_cnt[0] <= w_out.count_empty;
                r_cnt[1] <= w_out.count_first;
                r_cnt[2] <= w_out.count_second;
                r_cnt[3] <= w_out.count_third;
            end
            if (w_emit)   r_owp <= ~r_owp;
            if (w_pop_ok) r_orp <= ~r_orp;
            r_ocnt <= r_ocnt + 2'(w_emit) - 2'(w_pop_ok);
        end
    end

`ifndef SYNTHESIS
    a_oq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> r_ocnt != 2'd2) else $error("result queue overflow");
    a_take_with_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take == w_emit) else $error("command retired without result");
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |-> i_cmd_valid) else $error("take of empty command queue");
    a_wrp_follows_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WRP |-> $past(r_state) == ST_EXEC) else $error("bad swap write");
`endif

endmodule

[rtl/cyclic_competition_lattice_step_core.sv]
// top level of the cyclic competition lattice step core
// A toroidal rock-paper-scissors lattice kept in one memory addressed {row, col}. After
// reset the lattice is cleared one cell a cycle, all 2**(clog2(COLS)+clog2(ROWS)) cells
// (COLS*ROWS for power-of-two sizes); the two-entry input queue still takes items
// meanwhile and full rises once it holds two. The back end takes a write item or an
// interaction on an empty site through idle and neighbour read, an occupied site adds
// execute and a swap adds the second write; the memory does one read and one write per
// cycle and sets this. Configuration writes take effect at once.
module cyclic_competition_lattice_step_core
    import cclat_pkg::*;
#(
    parameter int unsigned COLS = 512,
    parameter int unsigned ROWS = 512
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [CfgW-1:0] i_cfg_data,
    input  logic            push,
    output logic            full,
    input  t_in_item        i_item,
    output logic            empty,
    input  logic            pop,
    output t_out_item       o_item
);

    localparam int unsigned CW = $clog2(COLS);
    localparam int unsigned RW = $clog2(ROWS);
    localparam int unsigned AW = CW + RW;

    logic [CfgW-1:0] r_mob, r_repw, r_pred;
    logic            w_cv, w_take, w_func, w_full_q;
    logic [AW-1:0]   w_act, w_pas;
    logic [1:0]      w_sp;
    logic [DrawW-1:0] w_da, w_dp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mob  <= MobilityReset;
            r_repw <= ReproWidthReset;
            r_pred <= PredationReset;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MOBILITY:  r_mob  <= i_cfg_data;
                CFG_REPRO:     r_repw <= i_cfg_data;
                CFG_PREDATION: r_pred <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign full = w_full_q;

    cclat_front #(.COLS(COLS), .ROWS(ROWS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .o_full(w_full_q), .i_item(i_item),
        .o_cmd_valid(w_cv), .i_cmd_take(w_take), .o_cmd_func(w_func),
        .o_cmd_act(w_act), .o_cmd_pas(w_pas), .o_cmd_species(w_sp),
        .o_cmd_draw_a(w_da), .o_cmd_draw_p(w_dp)
    );

    cclat_back #(.COLS(COLS), .ROWS(ROWS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_mob(r_mob), .i_repw(r_repw), .i_pred(r_pred),
        .i_cmd_valid(w_cv), .o_cmd_take(w_take), .i_cmd_func(w_func),
        .i_cmd_act(w_act), .i_cmd_pas(w_pas), .i_cmd_species(w_sp),
        .i_cmd_draw_a(w_da), .i_cmd_draw_p(w_dp),
        .o_empty(empty), .i_pop(pop), .o_item(o_item)
    );

endmodule
